// File: rtl/grid_min_cost_path_assert.svh
// ---------------------------------------------------------------------------
// grid_min_cost_path assertion macros
// Implication checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_MIN_COST_PATH_ASSERT_SVH
`define GRID_MIN_COST_PATH_ASSERT_SVH

// same-cycle implication
`define GMCP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid_min_cost_path check failed");

// next-cycle implication
`define GMCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid_min_cost_path check failed");

`endif

// File: rtl/gmcp_pkg.sv
// ---------------------------------------------------------------------------
// gmcp_pkg
// Types and constants of the grid minimum-cost path search.
// ---------------------------------------------------------------------------
`default_nettype none

package gmcp_pkg;

  localparam int COST_W   = 22;
  localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;
  localparam int DIM_W    = 4;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 5;

  localparam logic [2:0] REG_GRID_ROWS = 3'd0;
  localparam logic [2:0] REG_GRID_COLS = 3'd1;
  localparam logic [2:0] REG_START_ROW = 3'd2;
  localparam logic [2:0] REG_START_COL = 3'd3;
  localparam logic [2:0] REG_END_ROW   = 3'd4;
  localparam logic [2:0] REG_END_COL   = 3'd5;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK0,
    S_CHK1,
    S_CHK2,
    S_SCAN,
    S_NB,
    S_RLX,
    S_PATH_RD,
    S_PATH_WT,
    S_EMIT_RD,
    S_EMIT_WR,
    S_NONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/grid_min_cost_path.sv
// ---------------------------------------------------------------------------
// grid_min_cost_path
// Loads a weighted grid cell by cell, then runs a 4-neighbour Dijkstra
// search with one shared compare/add unit and streams out the path.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | cell_weight
//  out_    | output    | out_valid/out_ready| found, total_cost, path_row/col, last_step
//  cfg_    | APB slave | psel/penable       | six 4-bit registers at 4*i
//
//  Loading accepts one cell per cycle. After the last cell the search runs:
//  each settle step scans all T cells of the single-port best-cost memory,
//  then relaxes up to four neighbours of the chosen cell. The path walk
//  follows the predecessors from the end cell back to the start; emission
//  then streams the path cells out. in_ready is low from the last cell until the
//  final result is in the output register. Reset is synchronous, active low;
//  the output register holds while out_ready is low.
`default_nettype none

module grid_min_cost_path
  import gmcp_pkg::*;
#(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [WEIGHT_BITS-1:0] in_cell_weight,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_found,
  output logic [COST_W-1:0]           out_total_cost,
  output logic [DIM_W-1:0]            out_path_row,
  output logic [DIM_W-1:0]            out_path_col,
  output logic                        out_last_step,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_AW-1:0]      cfg_paddr,
  input  wire logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]           cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int PW     = CNT_W + 8;
  localparam int SUM_W  = ((COST_W > WEIGHT_BITS) ? COST_W : WEIGHT_BITS) + 1;
  localparam int PR_W   = CELL_W + 2 * DIM_W;

  // configuration
  logic [DIM_W-1:0] rows_cfg_r, cols_cfg_r, srow_r, scol_r, erow_r, ecol_r;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  // memories
  logic [WEIGHT_BITS-1:0] wmem [CELLS];
  logic [COST_W-1:0]      bcmem [CELLS];
  logic [PR_W-1:0]        prmem [CELLS];
  logic [2*DIM_W-1:0]     stk [CELLS];
  logic [WEIGHT_BITS-1:0] w_q_r;
  logic [COST_W-1:0]      bc_q_r;
  logic [PR_W-1:0]        pr_q_r;
  logic [2*DIM_W-1:0]     stk_q_r;
  logic [CELLS-1:0]       valid_r, settled_r;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  ld_idx_r, ld_eff;
  logic              ld_last, in_acc;
  logic [DIM_W-1:0]  rows, cols;
  logic [CNT_W-1:0]  total;
  logic [PW-1:0]     total_full, s_full, e_full;
  logic [CELL_W-1:0] s_idx, e_idx;
  logic              ends_ok;

  // scan
  logic [CNT_W-1:0]  scan_i_r;
  logic [DIM_W-1:0]  scan_row_r, scan_col_r;
  logic              p_v_r;
  logic [CELL_W-1:0] p_idx_r;
  logic [DIM_W-1:0]  p_row_r, p_col_r;
  logic              have_u_r, cand, scan_done, scan_init;
  logic [COST_W-1:0] bu_r;
  logic [CELL_W-1:0] u_idx_r;
  logic [DIM_W-1:0]  u_row_r, u_col_r;

  // relax
  logic [1:0]        k_r;
  logic              nb_ok;
  logic [CELL_W-1:0] nb_v, v_r;
  logic [SUM_W-1:0]  sum;
  logic [COST_W-1:0] nd;
  logic              better;

  // path
  logic [CNT_W-1:0]  n_r, ptr_r;
  logic [CELL_W-1:0] c_idx_r;
  logic [DIM_W-1:0]  c_row_r, c_col_r;
  logic [COST_W-1:0] total_r;
  logic              out_free;

  logic [CELL_W-1:0] w_addr, bc_addr;

  // -------------------------------------------------------------------------
  // grid geometry
  // -------------------------------------------------------------------------
  always_comb begin
    if (rows_cfg_r == '0) rows = DIM_W'(1);
    else if (32'(rows_cfg_r) > MAX_ROWS) rows = DIM_W'(MAX_ROWS);
    else rows = rows_cfg_r;
    if (cols_cfg_r == '0) cols = DIM_W'(1);
    else if (32'(cols_cfg_r) > MAX_COLS) cols = DIM_W'(MAX_COLS);
    else cols = cols_cfg_r;
  end

  assign total_full = PW'(rows) * PW'(cols);
  assign total      = total_full[CNT_W-1:0];
  assign s_full     = PW'(srow_r - DIM_W'(1)) * PW'(cols) + PW'(scol_r - DIM_W'(1));
  assign e_full     = PW'(erow_r - DIM_W'(1)) * PW'(cols) + PW'(ecol_r - DIM_W'(1));
  assign s_idx      = s_full[CELL_W-1:0];
  assign e_idx      = e_full[CELL_W-1:0];
  assign ends_ok    = (srow_r != '0) && (srow_r <= rows) && (scol_r != '0) &&
                      (scol_r <= cols) && (erow_r != '0) && (erow_r <= rows) &&
                      (ecol_r != '0) && (ecol_r <= cols);

  assign ld_eff  = (ld_idx_r >= total) ? '0 : ld_idx_r;
  assign ld_last = ((ld_eff + CNT_W'(1)) == total);
  assign in_acc  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign scan_done = (scan_i_r == total) && !p_v_r;
  assign cand = p_v_r && valid_r[p_idx_r] && !settled_r[p_idx_r] &&
                (!have_u_r || (bc_q_r < bu_r));

  // neighbour of the cell being settled
  always_comb begin
    nb_ok  = 1'b0;
    nb_v   = u_idx_r;
    case (k_r)
      DIR_UP: begin
        nb_ok  = (u_row_r > DIM_W'(1));
        nb_v   = u_idx_r - CELL_W'(cols);
      end
      DIR_DOWN: begin
        nb_ok  = (u_row_r < rows);
        nb_v   = u_idx_r + CELL_W'(cols);
      end
      DIR_LEFT: begin
        nb_ok  = (u_col_r > DIM_W'(1));
        nb_v   = u_idx_r - CELL_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = (u_col_r < cols);
        nb_v   = u_idx_r + CELL_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // shared add and compare
  assign sum = SUM_W'(bu_r) + ((v_r == e_idx) ? '0 : SUM_W'(w_q_r));
  assign nd  = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
  assign better = (w_q_r != '0) && (!valid_r[v_r] || (nd < bc_q_r));

  // -------------------------------------------------------------------------
  // next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_acc && ld_last) state_nxt = S_CHK0;
      S_CHK0:    state_nxt = ends_ok ? S_CHK1 : S_NONE;
      // start weight is back here, end weight in S_CHK2
      S_CHK1:    state_nxt = (w_q_r == '0) ? S_NONE : S_CHK2;
      S_CHK2:    state_nxt = (w_q_r == '0) ? S_NONE : S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          if (!have_u_r) state_nxt = S_NONE;
          else if (u_idx_r == e_idx) state_nxt = S_PATH_RD;
          else state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (nb_ok) state_nxt = S_RLX;
        else if (k_r == DIR_RIGHT) state_nxt = S_SCAN;
      end
      S_RLX:     state_nxt = (k_r == DIR_RIGHT) ? S_SCAN : S_NB;
      S_PATH_RD: state_nxt = (c_idx_r == s_idx) ? S_EMIT_RD : S_PATH_WT;
      S_PATH_WT: state_nxt = S_PATH_RD;
      S_EMIT_RD: state_nxt = S_EMIT_WR;
      S_EMIT_WR: begin
        if (out_free) state_nxt = (ptr_r == '0) ? S_IDLE : S_EMIT_RD;
      end
      S_NONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // state outputs: ready and memory read addresses
  // -------------------------------------------------------------------------
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    scan_init = (state_nxt == S_SCAN) && (state_r != S_SCAN);
    w_addr    = nb_v;
    bc_addr   = nb_v;
    case (state_r)
      S_CHK0:  w_addr = s_idx;
      S_CHK1:  w_addr = e_idx;
      S_SCAN:  bc_addr = scan_i_r[CELL_W-1:0];
      default: w_addr = nb_v;
    endcase
  end

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_GRID_ROWS: cfg_prdata = CFG_DW'(rows_cfg_r);
      REG_GRID_COLS: cfg_prdata = CFG_DW'(cols_cfg_r);
      REG_START_ROW: cfg_prdata = CFG_DW'(srow_r);
      REG_START_COL: cfg_prdata = CFG_DW'(scol_r);
      REG_END_ROW:   cfg_prdata = CFG_DW'(erow_r);
      REG_END_COL:   cfg_prdata = CFG_DW'(ecol_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // memories
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) wmem[ld_eff[CELL_W-1:0]] <= in_cell_weight;
    w_q_r <= wmem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHK2) bcmem[s_idx] <= '0;
    else if (state_r == S_RLX && better) bcmem[v_r] <= nd;
    bc_q_r <= bcmem[bc_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RLX && better) prmem[v_r] <= {u_idx_r, u_row_r, u_col_r};
    pr_q_r <= prmem[c_idx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PATH_RD) stk[n_r[CELL_W-1:0]] <= {c_row_r, c_col_r};
    stk_q_r <= stk[ptr_r[CELL_W-1:0]];
  end

  // -------------------------------------------------------------------------
  // control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ld_idx_r   <= '0;
      out_valid  <= 1'b0;
      rows_cfg_r <= DIM_W'(8);
      cols_cfg_r <= DIM_W'(8);
      srow_r     <= DIM_W'(1);
      scol_r     <= DIM_W'(1);
      erow_r     <= DIM_W'(8);
      ecol_r     <= DIM_W'(8);
      valid_r    <= '0;
      settled_r  <= '0;
      p_v_r      <= 1'b0;
      have_u_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a register write restarts loading
      if (cfg_wr && cfg_idx <= REG_END_COL) ld_idx_r <= '0;
      else if (in_acc) ld_idx_r <= ld_last ? '0 : ld_eff + CNT_W'(1);
      if (cfg_wr) begin
        case (cfg_idx)
          REG_GRID_ROWS: rows_cfg_r <= cfg_pwdata[DIM_W-1:0];
          REG_GRID_COLS: cols_cfg_r <= cfg_pwdata[DIM_W-1:0];
          REG_START_ROW: srow_r     <= cfg_pwdata[DIM_W-1:0];
          REG_START_COL: scol_r     <= cfg_pwdata[DIM_W-1:0];
          REG_END_ROW:   erow_r     <= cfg_pwdata[DIM_W-1:0];
          REG_END_COL:   ecol_r     <= cfg_pwdata[DIM_W-1:0];
          default:       ;
        endcase
      end
      if ((state_r == S_EMIT_WR || state_r == S_NONE) && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      // clear search flags at search start
      if (state_r == S_CHK2) begin
        valid_r   <= CELLS'(1) << s_idx;
        settled_r <= '0;
      end
      if (state_r == S_RLX && better) valid_r[v_r] <= 1'b1;

      if (scan_init) begin
        p_v_r    <= 1'b0;
        have_u_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        p_v_r <= (scan_i_r != total);
        if (cand) have_u_r <= 1'b1;
        if (scan_done && have_u_r) settled_r[u_idx_r] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (scan_init) begin
      scan_i_r   <= '0;
      scan_row_r <= DIM_W'(1);
      scan_col_r <= DIM_W'(1);
    end else if (state_r == S_SCAN) begin
      if (scan_i_r != total) begin
        scan_i_r <= scan_i_r + CNT_W'(1);
        if (scan_col_r == cols) begin
          scan_col_r <= DIM_W'(1);
          scan_row_r <= scan_row_r + DIM_W'(1);
        end else begin
          scan_col_r <= scan_col_r + DIM_W'(1);
        end
      end
      p_idx_r <= scan_i_r[CELL_W-1:0];
      p_row_r <= scan_row_r;
      p_col_r <= scan_col_r;
      if (cand) begin
        bu_r    <= bc_q_r;
        u_idx_r <= p_idx_r;
        u_row_r <= p_row_r;
        u_col_r <= p_col_r;
      end
      if (scan_done) begin
        k_r     <= DIR_UP;
        total_r <= bu_r;
        n_r     <= '0;
        c_idx_r <= e_idx;
        c_row_r <= erow_r;
        c_col_r <= ecol_r;
      end
    end

    case (state_r)
      S_NB: begin
        v_r <= nb_v;
        if (!nb_ok) k_r <= k_r + 2'd1;
      end
      S_RLX: k_r <= k_r + 2'd1;
      S_PATH_RD: begin
        n_r   <= n_r + CNT_W'(1);
        ptr_r <= n_r;
      end
      S_PATH_WT: begin
        // step to the predecessor
        {c_idx_r, c_row_r, c_col_r} <= pr_q_r;
      end
      S_EMIT_WR: begin
        if (out_free && ptr_r != '0) ptr_r <= ptr_r - CNT_W'(1);
      end
      default: ;
    endcase

    if (state_r == S_EMIT_WR && out_free) begin
      out_found      <= 1'b1;
      out_total_cost <= total_r;
      out_path_row   <= stk_q_r[2*DIM_W-1:DIM_W];
      out_path_col   <= stk_q_r[DIM_W-1:0];
      out_last_step  <= (ptr_r == '0);
    end else if (state_r == S_NONE && out_free) begin
      out_found      <= 1'b0;
      out_total_cost <= '0;
      out_path_row   <= '0;
      out_path_col   <= '0;
      out_last_step  <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
`include "grid_min_cost_path_assert.svh"

  `GMCP_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_total_cost) && $stable(out_path_row) && $stable(out_path_col) && $stable(out_last_step))
  `GMCP_ASSERT_SAME(a_none_is_last, out_valid && !out_found, out_last_step)
  `GMCP_ASSERT_SAME(a_none_zero, out_valid && !out_found,
                    out_total_cost == '0 && out_path_row == '0 && out_path_col == '0)
  `GMCP_ASSERT_SAME(a_found_cell, out_valid && out_found,
                    out_path_row != '0 && out_path_col != '0)

endmodule

`default_nettype wire
